FILE: rtl/rtp_g711_payload_decoder_defines.svh
// -----------------------------------------------------------------------------
// rtp_g711_payload_decoder_defines
// Assertion macros shared by the RTP G.711 payload decoder modules.
// -----------------------------------------------------------------------------
`ifndef RTP_G711_PAYLOAD_DECODER_DEFINES_SVH
`define RTP_G711_PAYLOAD_DECODER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define RGPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RGPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rgpd_pkg.sv
// -----------------------------------------------------------------------------
// rgpd_pkg
// Constants and types shared by the RTP G.711 payload decoder.
// -----------------------------------------------------------------------------
package rgpd_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 1500;

    // RTP fixed header length in bytes.
    localparam int FIXED_HEADER = 12;

    // Payload types of interest.
    localparam logic [6:0] PT_PCMU      = 7'd0;
    localparam logic [6:0] PT_CN        = 7'd13;
    localparam logic [6:0] PT_DYN_FIRST = 7'd96;

    // Entries in the queue between parser and expander.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       ulaw;
    } rgpd_entry_t;

endpackage

FILE: rtl/rtp_g711_payload_decoder.sv
// -----------------------------------------------------------------------------
// rtp_g711_payload_decoder
// RTP packet byte stream in, G.711-expanded 16-bit PCM samples out.
// -----------------------------------------------------------------------------
// One packet byte is taken per cycle on the slave stream while the queue
// has room, tlast marking the final byte. The parser skips the fixed header,
// CSRC list and extension, drops packets of comfort-noise or dynamic payload
// type, and queues each payload byte; the expander decodes it (mu-law for
// type 0, A-law otherwise) into a registered sample on the master stream,
// with tlast set when the sample came from the packet's last byte. Sustained
// rate is one byte per cycle while the output is not stalled; each sample
// passes through the parser-to-expander queue and the output register. A
// two-entry queue keeps input flowing while the output is stalled, until it
// fills. Bytes at or beyond MAX_PACKET_BYTES produce nothing but honor tlast.
module rtp_g711_payload_decoder #(
    parameter int MAX_PACKET_BYTES = rgpd_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] pcm_sample
    output logic        m_tlast
);
    import rgpd_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    rgpd_entry_t q_push_entry;
    rgpd_entry_t q_head;

    rgpd_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_push_entry)
    );

    rgpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    rgpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

FILE: rtl/rgpd_front.sv
// -----------------------------------------------------------------------------
// rgpd_front
// Packet parser: tracks the byte position, skips the RTP header, CSRC list and
// extension, and queues every decodable payload byte below MAX_PACKET_BYTES.
// -----------------------------------------------------------------------------
`include "rtp_g711_payload_decoder_defines.svh"

module rgpd_front #(
    parameter int MAX_PACKET_BYTES = rgpd_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] data_byte
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output rgpd_pkg::rgpd_entry_t q_entry
);
    import rgpd_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int SUM_W = ((POS_W > 18) ? POS_W : 18) + 1;
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_FIXED = POS_W'(FIXED_HEADER);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] hdr_end_reg, hdr_end_next;
    logic             ext_reg, ext_next;
    logic [6:0]       pt_reg, pt_next;
    logic [7:0]       ext_len_hi_reg, ext_len_hi_next;
    logic             drop_reg, drop_next;

    logic             accept;
    logic [SUM_W-1:0] csrc_end;
    logic [SUM_W-1:0] ext_end;
    logic [POS_W-1:0] csrc_end_clamped;
    logic [POS_W-1:0] ext_end_clamped;
    logic [POS_W:0]   ext_len_hi_pos;
    logic [POS_W:0]   ext_len_lo_pos;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Header end candidates, saturated at the maximum packet size.
    assign csrc_end = SUM_W'(FIXED_HEADER) + {{(SUM_W-6){1'b0}}, s_tdata[3:0], 2'b00};
    assign ext_end  = SUM_W'(hdr_end_reg) + SUM_W'(4)
                    + {{(SUM_W-18){1'b0}}, ext_len_hi_reg, s_tdata, 2'b00};
    assign csrc_end_clamped = (csrc_end > SUM_W'(MAX_PACKET_BYTES)) ? POS_MAX
                                                                    : csrc_end[POS_W-1:0];
    assign ext_end_clamped  = (ext_end > SUM_W'(MAX_PACKET_BYTES)) ? POS_MAX
                                                                   : ext_end[POS_W-1:0];

    assign ext_len_hi_pos = {1'b0, hdr_end_reg} + (POS_W+1)'(2);
    assign ext_len_lo_pos = {1'b0, hdr_end_reg} + (POS_W+1)'(3);

    assign q_entry.code = s_tdata;
    assign q_entry.last = s_tlast;
    assign q_entry.ulaw = (pt_reg == PT_PCMU);

    always_comb
    begin
        pos_next        = pos_reg;
        hdr_end_next    = hdr_end_reg;
        ext_next        = ext_reg;
        pt_next         = pt_reg;
        ext_len_hi_next = ext_len_hi_reg;
        drop_next       = drop_reg;
        q_push          = 1'b0;

        if (accept)
        begin
            if (pos_reg < POS_MAX)
            begin
                if (pos_reg == '0)
                begin
                    hdr_end_next = csrc_end_clamped;
                    ext_next     = s_tdata[4];
                end
                else if (pos_reg == POS_W'(1))
                begin
                    pt_next   = s_tdata[6:0];
                    drop_next = (s_tdata[6:0] == PT_CN) || (s_tdata[6:0] >= PT_DYN_FIRST);
                end

                if (pos_reg >= POS_FIXED && ext_reg)
                begin
                    if ({1'b0, pos_reg} == ext_len_hi_pos)
                    begin
                        ext_len_hi_next = s_tdata;
                    end
                    else if ({1'b0, pos_reg} == ext_len_lo_pos)
                    begin
                        hdr_end_next = ext_end_clamped;
                        ext_next     = 1'b0;
                    end
                end
                else if (pos_reg >= POS_FIXED && pos_reg >= hdr_end_reg && !drop_reg)
                begin
                    q_push = 1'b1;
                end
                pos_next = pos_reg + POS_W'(1);
            end

            // The last byte returns all packet state to its idle values.
            if (s_tlast)
            begin
                pos_next        = '0;
                hdr_end_next    = POS_FIXED;
                ext_next        = 1'b0;
                pt_next         = '0;
                ext_len_hi_next = '0;
                drop_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            hdr_end_reg    <= POS_FIXED;
            ext_reg        <= 1'b0;
            pt_reg         <= '0;
            ext_len_hi_reg <= '0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            hdr_end_reg    <= hdr_end_next;
            ext_reg        <= ext_next;
            pt_reg         <= pt_next;
            ext_len_hi_reg <= ext_len_hi_next;
            drop_reg       <= drop_next;
        end
    end

    `RGPD_ASSERT_NEXT(a_last_clears_pos, accept && s_tlast, pos_reg == '0,
        "byte position not cleared after the last byte")
    `RGPD_ASSERT_NOW(a_pos_in_range, 1'b1, pos_reg <= POS_MAX,
        "byte position beyond the maximum packet size")
    `RGPD_ASSERT_NOW(a_hdr_end_range, 1'b1,
        hdr_end_reg >= POS_FIXED && hdr_end_reg <= POS_MAX,
        "header end outside its legal range")

endmodule

FILE: rtl/rgpd_queue.sv
// -----------------------------------------------------------------------------
// rgpd_queue
// Short register queue that decouples the parser from the expander.
// -----------------------------------------------------------------------------
`include "rtp_g711_payload_decoder_defines.svh"

module rgpd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rgpd_pkg::rgpd_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output rgpd_pkg::rgpd_entry_t head
);
    import rgpd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rgpd_entry_t      store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RGPD_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH),
        "queue count exceeds its depth")
    `RGPD_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1),
        "queue count did not grow on a push")
    `RGPD_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - CNT_W'(1),
        "queue count did not shrink on a pop")

endmodule

FILE: rtl/rgpd_back.sv
// -----------------------------------------------------------------------------
// rgpd_back
// G.711 expander: turns queued payload bytes into 16-bit linear samples and
// holds each one in the output register until it is taken.
// -----------------------------------------------------------------------------
module rgpd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  rgpd_pkg::rgpd_entry_t q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] pcm_sample
    output logic                  m_tlast
);
    import rgpd_pkg::*;

    logic        valid_reg, valid_next;
    logic [15:0] sample_reg;
    logic        last_reg;
    logic [15:0] sample;

    function automatic logic [15:0] alaw_expand(input logic [7:0] code);
        logic [7:0]  a;
        logic [2:0]  seg;
        logic [15:0] mag;
        a   = code ^ 8'h55;
        seg = a[6:4];
        if (seg == 3'd0)
        begin
            mag = {8'd0, a[3:0], 4'd0} + 16'h0008;
        end
        else
        begin
            mag = ({8'd0, a[3:0], 4'd0} + 16'h0108) << (seg - 3'd1);
        end
        return a[7] ? mag : 16'd0 - mag;
    endfunction

    function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
        logic [7:0]  u;
        logic [15:0] mag;
        u   = ~code;
        mag = ({9'd0, u[3:0], 3'd0} + 16'h0084) << u[6:4];
        return u[7] ? 16'h0084 - mag : mag - 16'h0084;
    endfunction

    assign sample = q_head.ulaw ? ulaw_expand(q_head.code) : alaw_expand(q_head.code);

    // Load a new sample whenever the output register is free or being emptied.
    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg <= sample;
            last_reg   <= q_head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = sample_reg;
    assign m_tlast  = last_reg;

endmodule
